[rtl/bcrf_pkg.sv]
// ----------------------------------------------------------------------------
// bcrf_pkg
// Shared constants and types of the border connected region fill core.
// ----------------------------------------------------------------------------
package bcrf_pkg;

  localparam int unsigned MAX_SIDE_DEF = 8;
  localparam int unsigned SIDE_W       = 4;
  localparam logic [SIDE_W-1:0] SIDE_RESET = 4'd4;

  typedef struct packed {
    logic empty;
  } bcrf_queue_status_t;

endpackage

[rtl/border_connected_region_fill_core.sv]
// ----------------------------------------------------------------------------
// border_connected_region_fill_core
// Loads a square open/blocked grid, flood fills from the open border cells
// and streams the grid back with enclosed open regions blocked.
// ----------------------------------------------------------------------------
// Cells of an N x N grid (N from the side register, clamped to 1..MAX_SIDE)
// arrive one per cycle in row-major order; open border cells are queued as
// they load. After the last cell the input is not ready while a sequencer
// drains the work queue: each popped cell passes ST_POP and ST_POPW, then
// each of its four neighbors passes ST_NB and, when inside the grid, ST_CHK,
// all through the one grid memory read port. Results then stream out one per
// cycle while m_axis_tready is high, N*N of them, tlast on the final cell.
// A side write restarts the grid being loaded and also aborts a fill or output.
module border_connected_region_fill_core import bcrf_pkg::*; #(
  parameter int unsigned MAX_SIDE = MAX_SIDE_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [SIDE_W-1:0] cfg_data_i,      // grid_side
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,    // [0] cell_open
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [7:0]        m_axis_tdata,    // [0] cell_kept_open
  output logic              m_axis_tlast     // last_cell
);

  localparam int unsigned RW    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int unsigned AW    = 2 * RW;
  localparam int unsigned DEPTH = 1 << AW;
  localparam int unsigned SW    = RW + 1;

  localparam logic [2:0] ST_LOAD = 3'd0;
  localparam logic [2:0] ST_POP  = 3'd1;
  localparam logic [2:0] ST_POPW = 3'd2;
  localparam logic [2:0] ST_NB   = 3'd3;
  localparam logic [2:0] ST_CHK  = 3'd4;
  localparam logic [2:0] ST_EMIT = 3'd5;

  logic [2:0]        state_q, state_d;
  logic [SIDE_W-1:0] side_q;
  logic [SW-1:0]     side;
  logic [RW-1:0]     last_rc;
  logic [RW-1:0]     row_q, row_d, col_q, col_d;
  logic [RW-1:0]     cur_r_q, cur_r_d, cur_c_q, cur_c_d;
  logic [1:0]        dir_q, dir_d;
  logic [AW-1:0]     nb_addr_q, nb_addr_d;
  logic [1:0]        grid_mem_q [DEPTH];   // [1] reached, [0] open
  logic [1:0]        grid_rd_q;
  logic              grid_wr, grid_rd;
  logic [AW-1:0]     grid_wr_addr, grid_rd_addr;
  logic [1:0]        grid_wr_data;

  logic               q_clear, q_push, q_pop;
  logic [AW-1:0]      q_push_data, q_pop_data;
  bcrf_queue_status_t q_status;

  logic in_xfer, out_xfer, cfg_xfer, cell_bit, on_border, at_last;
  logic nb_ok;
  logic [RW-1:0] nb_r, nb_c;

  always_comb begin
    if (side_q == '0)                          side = SW'(1);
    else if (side_q > SIDE_W'(MAX_SIDE))       side = SW'(MAX_SIDE);
    else                                       side = side_q[SW-1:0];
  end
  assign last_rc = RW'(side - SW'(1));

  assign cfg_ready_o   = 1'b1;
  assign cfg_xfer      = cfg_valid_i;
  assign s_axis_tready = (state_q == ST_LOAD);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (state_q == ST_EMIT);
  assign out_xfer      = m_axis_tvalid && m_axis_tready;
  assign cell_bit      = s_axis_tdata[0];
  assign at_last       = (row_q == last_rc) && (col_q == last_rc);
  assign on_border     = (row_q == '0) || (col_q == '0) ||
                         (row_q == last_rc) || (col_q == last_rc);

  assign m_axis_tdata = {7'd0, grid_rd_q[1]};
  assign m_axis_tlast = at_last;

  always_comb begin
    nb_r  = cur_r_q;
    nb_c  = cur_c_q;
    nb_ok = 1'b0;
    case (dir_q)
      2'd0: begin
        nb_r  = cur_r_q - 1'b1;
        nb_ok = (cur_r_q != '0);
      end
      2'd1: begin
        nb_c  = cur_c_q - 1'b1;
        nb_ok = (cur_c_q != '0);
      end
      2'd2: begin
        nb_r  = cur_r_q + 1'b1;
        nb_ok = (cur_r_q != last_rc);
      end
      default: begin
        nb_c  = cur_c_q + 1'b1;
        nb_ok = (cur_c_q != last_rc);
      end
    endcase
  end

  always_comb begin
    state_d      = state_q;
    row_d        = row_q;
    col_d        = col_q;
    cur_r_d      = cur_r_q;
    cur_c_d      = cur_c_q;
    dir_d        = dir_q;
    nb_addr_d    = nb_addr_q;
    q_clear      = 1'b0;
    q_push       = 1'b0;
    q_push_data  = {row_q, col_q};
    q_pop        = 1'b0;
    grid_wr      = 1'b0;
    grid_wr_addr = {row_q, col_q};
    grid_wr_data = {cell_bit && on_border, cell_bit};
    grid_rd      = 1'b0;
    grid_rd_addr = {nb_r, nb_c};
    unique case (state_q)
      ST_LOAD: begin
        if (in_xfer) begin
          grid_wr = 1'b1;
          if (cell_bit && on_border) q_push = 1'b1;
          if (col_q == last_rc) begin
            col_d = '0;
            row_d = row_q + 1'b1;
          end else begin
            col_d = col_q + 1'b1;
          end
          if (at_last) begin
            row_d   = '0;
            col_d   = '0;
            state_d = ST_POP;
          end
        end
      end
      ST_POP: begin
        if (q_status.empty) begin
          grid_rd      = 1'b1;
          grid_rd_addr = {row_q, col_q};
          state_d      = ST_EMIT;
        end else begin
          q_pop   = 1'b1;
          state_d = ST_POPW;
        end
      end
      ST_POPW: begin
        cur_r_d = q_pop_data[AW-1:RW];
        cur_c_d = q_pop_data[RW-1:0];
        dir_d   = 2'd0;
        state_d = ST_NB;
      end
      ST_NB: begin
        if (nb_ok) begin
          grid_rd   = 1'b1;
          nb_addr_d = {nb_r, nb_c};
          state_d   = ST_CHK;
        end else begin
          dir_d = dir_q + 1'b1;
          if (dir_q == 2'd3) state_d = ST_POP;
        end
      end
      ST_CHK: begin
        q_push_data = nb_addr_q;
        if (grid_rd_q[0] && !grid_rd_q[1]) begin
          q_push       = 1'b1;
          grid_wr      = 1'b1;
          grid_wr_addr = nb_addr_q;
          grid_wr_data = 2'b11;
        end
        dir_d   = dir_q + 1'b1;
        state_d = (dir_q == 2'd3) ? ST_POP : ST_NB;
      end
      ST_EMIT: begin
        if (out_xfer) begin
          if (col_q == last_rc) begin
            col_d = '0;
            row_d = row_q + 1'b1;
          end else begin
            col_d = col_q + 1'b1;
          end
          if (at_last) begin
            row_d   = '0;
            col_d   = '0;
            q_clear = 1'b1;
            state_d = ST_LOAD;
          end
          grid_rd      = 1'b1;
          grid_rd_addr = {row_d, col_d};
        end
      end
      default: state_d = ST_LOAD;
    endcase
    if (cfg_xfer) begin
      row_d     = '0;
      col_d     = '0;
      q_clear   = 1'b1;
      q_push    = 1'b0;
      state_d   = ST_LOAD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_LOAD;
      side_q    <= SIDE_RESET;
      row_q     <= '0;
      col_q     <= '0;
      dir_q     <= '0;
    end else begin
      state_q   <= state_d;
      row_q     <= row_d;
      col_q     <= col_d;
      dir_q     <= dir_d;
      if (cfg_xfer) side_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_r_q   <= cur_r_d;
    cur_c_q   <= cur_c_d;
    nb_addr_q <= nb_addr_d;
    if (grid_wr) grid_mem_q[grid_wr_addr] <= grid_wr_data;
    if (grid_rd) grid_rd_q <= grid_mem_q[grid_rd_addr];
  end

  bcrf_queue #(
    .AW (AW)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_i     (q_clear),
    .push_i      (q_push),
    .push_data_i (q_push_data),
    .pop_i       (q_pop),
    .pop_data_o  (q_pop_data),
    .status_o    (q_status)
  );

endmodule

[rtl/bcrf_queue.sv]
// ----------------------------------------------------------------------------
// bcrf_queue
// Work queue of cell addresses: one write port, one registered read port,
// head and tail pointers that a single clear returns to zero.
// ----------------------------------------------------------------------------
module bcrf_queue import bcrf_pkg::*; #(
  parameter int unsigned AW = 6
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               clear_i,
  input  logic               push_i,
  input  logic [AW-1:0]      push_data_i,
  input  logic               pop_i,
  output logic [AW-1:0]      pop_data_o,
  output bcrf_queue_status_t status_o
);

  localparam int unsigned DEPTH = 1 << AW;

  logic [AW-1:0] mem_q [DEPTH];
  logic [AW:0]   head_q, head_d;
  logic [AW:0]   tail_q, tail_d;
  logic [AW-1:0] rd_q;

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    if (clear_i) begin
      head_d = '0;
      tail_d = '0;
    end else begin
      if (push_i) tail_d = tail_q + 1'b1;
      if (pop_i)  head_d = head_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[tail_q[AW-1:0]] <= push_data_i;
    if (pop_i)  rd_q <= mem_q[head_q[AW-1:0]];
  end

  assign pop_data_o     = rd_q;
  assign status_o.empty = (head_q == tail_q);

endmodule

[rtl/bcrf_checker.sv]
// ----------------------------------------------------------------------------
// bcrf_checker
// Port-level checks of the border connected region fill core.
// ----------------------------------------------------------------------------
module bcrf_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              cfg_valid_i,
  input logic              s_axis_tready,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [7:0]        m_axis_tdata,
  input logic              m_axis_tlast
);

  // input side and result side never open together
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while results pending");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready && !cfg_valid_i) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("stalled result changed");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=>
      (!m_axis_tvalid && s_axis_tready))
    else $error("results continue after last transfer");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[7:1] == 7'd0))
    else $error("result padding not zero");

endmodule

bind border_connected_region_fill_core bcrf_checker u_bcrf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .cfg_valid_i   (cfg_valid_i),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
